>>> rtl/wsfp_pkg.sv
// wsfp_pkg: shared types, codes and defaults of the websocket frame parser
// no dependencies; used by every module under rtl/ except wsfp_in_reg

package wsfp_pkg;

  // default for the top level parameter, and the mask key size in bytes
  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned MASK_BYTES      = 4;

  // result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic ERR_RSV = 1'b0;
  localparam logic ERR_BIG = 1'b1;

  // header byte fields and length codes
  localparam logic [7:0] FIN_BIT    = 8'h80;
  localparam logic [7:0] LOW7_MASK  = 8'h7f;
  localparam logic [7:0] OP_MASK    = 8'h0f;
  localparam logic [6:0] LEN7_MAX   = 7'd125;
  localparam logic [6:0] LEN_EXT16  = 7'd126;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // register map: word index taken from paddr[2]
  localparam logic REG_MAX_PAYLOAD = 1'b0;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'hffff_ffff;

  // parse phases
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic        error_code;
  } res_t;

endpackage

>>> rtl/wsfp_cfg.sv
// wsfp_cfg: APB-style register port holding the max payload limit
// depends on wsfp_pkg

module wsfp_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] max_payload
);

  logic [31:0] max_payload_r;
  logic [31:0] max_payload_nxt;
  logic        wr_en;

  // write strobe on the access phase
  assign wr_en = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    max_payload_nxt = max_payload_r;
    if (wr_en && paddr[2] == wsfp_pkg::REG_MAX_PAYLOAD) begin
      max_payload_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= wsfp_pkg::MAX_PAYLOAD_RST;
    end else begin
      max_payload_r <= max_payload_nxt;
    end
  end

  // read decode
  always_comb begin
    unique case (paddr[2])
      wsfp_pkg::REG_MAX_PAYLOAD: prdata = max_payload_r;
      default:                   prdata = 32'd0;
    endcase
  end

  assign max_payload = max_payload_r;

endmodule

>>> rtl/wsfp_in_reg.sv
// wsfp_in_reg: input register stage for the incoming byte stream
// no package dependency; feeds wsfp_parse

module wsfp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       room,
  output logic       s1_valid,
  output logic [7:0] s1_data
);

  logic       s1_valid_r;
  logic [7:0] s1_data_r;

  // held word cannot move on while the result side is full
  assign in_stall = s1_valid_r & ~room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_data_r <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

>>> rtl/wsfp_parse.sv
// wsfp_parse: frame header state machine, length decode, key capture, unmasking
// depends on wsfp_pkg

module wsfp_parse #(
  parameter int unsigned LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data,
  input  logic [31:0]       max_payload,
  output logic              res_vld,
  output wsfp_pkg::res_t    res
);

  localparam int unsigned LEN_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  wsfp_pkg::phase_t   phase_r, phase_nxt;
  logic [3:0]         hdr_cnt_r, hdr_cnt_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               over_r, over_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [31:0]        remaining_r, remaining_nxt;
  logic [1:0]         key_idx_r, key_idx_nxt;
  logic               fin_r, fin_nxt;
  logic [3:0]         opcode_r, opcode_nxt;
  logic               masked_r, masked_nxt;

  logic [LEN_W+7:0]   len_sh;
  logic [6:0]         low7;
  logic [7:0]         kb;
  logic               big;
  logic               do_hdr;
  logic [1:0]         kind;
  logic [7:0]         pbyte;
  logic               last;
  logic               ecode;

  assign len_sh = {len_r, data};
  assign low7   = data[6:0] & wsfp_pkg::LOW7_MASK[6:0];
  assign kb     = masked_r ? key_r[{~key_idx_r, 3'b000} +: 8] : 8'd0;

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    len_nxt       = len_r;
    over_nxt      = over_r;
    key_nxt       = key_r;
    remaining_nxt = remaining_r;
    key_idx_nxt   = key_idx_r;
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    masked_nxt    = masked_r;
    res_vld       = 1'b0;
    do_hdr        = 1'b0;
    big           = 1'b0;
    kind          = wsfp_pkg::KIND_HDR;
    pbyte         = 8'd0;
    last          = 1'b0;
    ecode         = wsfp_pkg::ERR_RSV;

    if (fire) begin
      unique case (phase_r)
        wsfp_pkg::PH_FIRST: begin
          fin_nxt    = |(data & wsfp_pkg::FIN_BIT);
          opcode_nxt = data[3:0] & wsfp_pkg::OP_MASK[3:0];
          masked_nxt = 1'b0;
          len_nxt    = '0;
          over_nxt   = 1'b0;
          if (data[6:4] != 3'd0) begin
            res_vld   = 1'b1;
            kind      = wsfp_pkg::KIND_ERR;
            last      = 1'b1;
            ecode     = wsfp_pkg::ERR_RSV;
            phase_nxt = wsfp_pkg::PH_ERROR;
          end else begin
            phase_nxt = wsfp_pkg::PH_SECOND;
          end
        end
        wsfp_pkg::PH_SECOND: begin
          masked_nxt = |(data & wsfp_pkg::FIN_BIT);
          over_nxt   = 1'b0;
          if (low7 <= wsfp_pkg::LEN7_MAX) begin
            len_nxt = LEN_W'(low7);
            if (masked_nxt) begin
              hdr_cnt_nxt = 4'(wsfp_pkg::MASK_BYTES);
              key_nxt     = 32'd0;
              phase_nxt   = wsfp_pkg::PH_KEY;
            end else begin
              do_hdr = 1'b1;
            end
          end else begin
            hdr_cnt_nxt = (low7 == wsfp_pkg::LEN_EXT16) ? wsfp_pkg::EXT16_BYTES
                                                        : wsfp_pkg::EXT64_BYTES;
            len_nxt     = '0;
            phase_nxt   = wsfp_pkg::PH_EXTLEN;
          end
        end
        wsfp_pkg::PH_EXTLEN: begin
          len_nxt     = len_sh[LEN_W-1:0];
          over_nxt    = over_r | (|len_sh[LEN_W+7:LEN_W]);
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_nxt == 4'd0) begin
            if (masked_r) begin
              hdr_cnt_nxt = 4'(wsfp_pkg::MASK_BYTES);
              key_nxt     = 32'd0;
              phase_nxt   = wsfp_pkg::PH_KEY;
            end else begin
              do_hdr = 1'b1;
            end
          end
        end
        wsfp_pkg::PH_KEY: begin
          key_nxt     = {key_r[23:0], data};
          hdr_cnt_nxt = hdr_cnt_r - 4'd1;
          if (hdr_cnt_nxt == 4'd0) begin
            do_hdr = 1'b1;
          end
        end
        wsfp_pkg::PH_PAYLOAD: begin
          key_idx_nxt   = key_idx_r + 2'd1;
          remaining_nxt = remaining_r - 32'd1;
          last          = (remaining_nxt == 32'd0);
          res_vld       = 1'b1;
          kind          = wsfp_pkg::KIND_DATA;
          pbyte         = data ^ kb;
          if (last) begin
            phase_nxt = wsfp_pkg::PH_FIRST;
          end
        end
        wsfp_pkg::PH_ERROR: begin
          phase_nxt = wsfp_pkg::PH_ERROR;
        end
        default: begin
          phase_nxt = wsfp_pkg::PH_ERROR;
        end
      endcase

      // end of header: size check, then header or error result
      if (do_hdr) begin
        big = over_nxt
           || ((64'(len_nxt) >> LENGTH_BITS) != 64'd0)
           || (len_nxt > LEN_W'(max_payload));
        res_vld = 1'b1;
        if (big) begin
          kind      = wsfp_pkg::KIND_ERR;
          last      = 1'b1;
          ecode     = wsfp_pkg::ERR_BIG;
          phase_nxt = wsfp_pkg::PH_ERROR;
        end else begin
          remaining_nxt = len_nxt[31:0];
          key_idx_nxt   = 2'd0;
          kind          = wsfp_pkg::KIND_HDR;
          last          = (len_nxt[31:0] == 32'd0);
          phase_nxt     = last ? wsfp_pkg::PH_FIRST : wsfp_pkg::PH_PAYLOAD;
        end
      end
    end
  end

  // result word built from the updated frame fields
  always_comb begin
    res.kind           = kind;
    res.fin            = fin_nxt;
    res.opcode         = opcode_nxt;
    res.masked         = masked_nxt;
    res.payload_length = (over_nxt || ((64'(len_nxt) >> 32) != 64'd0))
                         ? 32'hffff_ffff : len_nxt[31:0];
    res.payload_byte   = pbyte;
    res.last           = last;
    res.error_code     = ecode;
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wsfp_pkg::PH_FIRST;
      hdr_cnt_r   <= 4'd0;
      len_r       <= '0;
      over_r      <= 1'b0;
      key_r       <= 32'd0;
      remaining_r <= 32'd0;
      key_idx_r   <= 2'd0;
      fin_r       <= 1'b0;
      opcode_r    <= 4'd0;
      masked_r    <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      len_r       <= len_nxt;
      over_r      <= over_nxt;
      key_r       <= key_nxt;
      remaining_r <= remaining_nxt;
      key_idx_r   <= key_idx_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      masked_r    <= masked_nxt;
    end
  end

  // an error is final until reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wsfp_pkg::PH_ERROR |=> phase_r == wsfp_pkg::PH_ERROR)
    else $error("parser left the error phase");

  // header byte counter is live while collecting length or key
  a_hdr_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsfp_pkg::PH_EXTLEN || phase_r == wsfp_pkg::PH_KEY) |-> hdr_cnt_r != 4'd0)
    else $error("header byte count ran out inside header");

  // payload phase always has bytes left
  a_remaining_live: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == wsfp_pkg::PH_PAYLOAD |-> remaining_r != 32'd0)
    else $error("payload phase with no bytes remaining");

  // the final payload byte returns to header parsing
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.last && res.kind == wsfp_pkg::KIND_DATA) |=>
      phase_r == wsfp_pkg::PH_FIRST)
    else $error("frame did not end after last payload byte");

endmodule

>>> rtl/wsfp_out_reg.sv
// wsfp_out_reg: result register between the parser and the result channel
// depends on wsfp_pkg

module wsfp_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  wsfp_pkg::res_t res,
  input  logic           out_stall,
  output logic           out_valid,
  output wsfp_pkg::res_t out_res,
  output logic           room
);

  logic           out_valid_r;
  logic           out_valid_nxt;
  wsfp_pkg::res_t res_r;

  // free when empty or being taken this cycle
  assign room = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> rtl/websocket_frame_parser_top.sv
// websocket_frame_parser_top: websocket frame deframer, one stream byte per word
// depends on wsfp_pkg, wsfp_cfg, wsfp_in_reg, wsfp_parse, wsfp_out_reg
//
//   channel   handshake            payload
//   in_       in_valid / in_stall  in_data_byte
//   out_      out_valid / out_stall kind, fin, opcode, masked, payload_length,
//                                  payload_byte, last, error_code
//   cfg       psel/penable/pready  paddr, pwdata, prdata (max_payload at 0)
//
// one byte per clock sustained while the result register has room; each byte
// is held in the input register and its result, if any, in the result register
// the parse step (length shift and max payload compare) sets the clock
// a stalled result register holds the input register, which stalls the input
// reset (rst_n low, synchronous) returns to header parsing and clears errors

module websocket_frame_parser_top #(
  parameter int unsigned LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_masked,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  output logic        out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           room;
  logic           s1_valid;
  logic [7:0]     s1_data;
  logic           fire;
  logic           res_vld;
  logic [31:0]    max_payload;
  wsfp_pkg::res_t res;
  wsfp_pkg::res_t out_res;

  // configuration
  wsfp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  // input register
  wsfp_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .room         (room),
    .s1_valid     (s1_valid),
    .s1_data      (s1_data)
  );

  // held byte is parsed when the result side can take it
  assign fire = s1_valid & room;

  wsfp_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data        (s1_data),
    .max_payload (max_payload),
    .res_vld     (res_vld),
    .res         (res)
  );

  // result register
  wsfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire & res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .room      (room)
  );

  assign out_kind           = out_res.kind;
  assign out_fin            = out_res.fin;
  assign out_opcode         = out_res.opcode;
  assign out_masked         = out_res.masked;
  assign out_payload_length = out_res.payload_length;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_last           = out_res.last;
  assign out_error_code     = out_res.error_code;

endmodule

>>> tb/wsfp_frame_checker.sv
// wsfp_frame_checker: watches the byte, result and register ports of the frame parser
// keeps its own deframing state, predicts each result word and compares in order
// depends on wsfp_pkg

module wsfp_frame_checker #(
  parameter int unsigned LENGTH_BITS = wsfp_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_kind,
  input  logic        out_fin,
  input  logic [3:0]  out_opcode,
  input  logic        out_masked,
  input  logic [31:0] out_payload_length,
  input  logic [7:0]  out_payload_byte,
  input  logic        out_last,
  input  logic        out_error_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fault_count,
  output int          results_due
);
  import wsfp_pkg::*;

  // predicted result words, oldest first
  res_t frame_results_due[$];

  // shadow of the deframer state and the size limit
  logic [31:0] size_limit;
  phase_t      parse_ph;
  logic [3:0]  hdr_left;
  logic [63:0] len_acc;
  logic [31:0] key_word;
  logic [31:0] body_left;
  logic [1:0]  key_idx;
  logic        frm_fin;
  logic [3:0]  frm_op;
  logic        frm_masked;

  // result word carrying the current frame's header fields
  function automatic res_t frame_word(logic [1:0] kind, logic [7:0] pbyte, logic last,
                                      logic ecode);
    res_t r;
    r.kind           = kind;
    r.fin            = frm_fin;
    r.opcode         = frm_op;
    r.masked         = frm_masked;
    r.payload_length = (len_acc > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : len_acc[31:0];
    r.payload_byte   = pbyte;
    r.last           = last;
    r.error_code     = ecode;
    return r;
  endfunction

  // header complete: size check, then header word or oversize error
  task automatic finish_header(output bit got, output res_t r);
    logic too_big;
    too_big = (len_acc > {32'd0, size_limit}) || ((len_acc >> LENGTH_BITS) != 64'd0);
    got = 1'b1;
    if (too_big) begin
      r = frame_word(KIND_ERR, 8'h00, 1'b1, ERR_BIG);
      parse_ph = PH_ERROR;
    end else begin
      body_left = len_acc[31:0];
      key_idx = 2'd0;
      if (body_left == 32'd0) begin
        r = frame_word(KIND_HDR, 8'h00, 1'b1, 1'b0);
        parse_ph = PH_FIRST;
      end else begin
        r = frame_word(KIND_HDR, 8'h00, 1'b0, 1'b0);
        parse_ph = PH_PAYLOAD;
      end
    end
  endtask

  // length known: either collect the mask key or close the header
  task automatic length_known(output bit got, output res_t r);
    got = 1'b0;
    r = '0;
    if (frm_masked) begin
      hdr_left = 4'(MASK_BYTES);
      key_word = 32'd0;
      parse_ph = PH_KEY;
    end else begin
      finish_header(got, r);
    end
  endtask

  // one stream byte through the shadow deframer
  task automatic deframe_byte(input logic [7:0] b, output bit got, output res_t r);
    logic [31:0] key_sh;
    got = 1'b0;
    r = '0;
    case (parse_ph)
      PH_FIRST: begin
        frm_fin = ((b & FIN_BIT) != 8'h00);
        frm_op = b[3:0];
        frm_masked = 1'b0;
        len_acc = 64'd0;
        if ((b & LOW7_MASK) > OP_MASK) begin
          r = frame_word(KIND_ERR, 8'h00, 1'b1, ERR_RSV);
          got = 1'b1;
          parse_ph = PH_ERROR;
        end else begin
          parse_ph = PH_SECOND;
        end
      end
      PH_SECOND: begin
        frm_masked = b[7];
        if (b[6:0] <= LEN7_MAX) begin
          len_acc = {57'd0, b[6:0]};
          length_known(got, r);
        end else begin
          hdr_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_acc = 64'd0;
          parse_ph = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) length_known(got, r);
      end
      PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) finish_header(got, r);
      end
      PH_PAYLOAD: begin
        // key bytes are used msb first, cycling every four bytes
        key_sh = frm_masked ? (key_word >> (8 * (3 - key_idx))) : 32'd0;
        key_idx = key_idx + 2'd1;
        body_left = body_left - 32'd1;
        r = frame_word(KIND_DATA, b ^ key_sh[7:0], body_left == 32'd0, 1'b0);
        got = 1'b1;
        if (body_left == 32'd0) parse_ph = PH_FIRST;
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
      fault_count++;
    end
  endtask

  // result check, byte prediction and register tracking at each edge
  always @(posedge clk) begin : watch
    bit   got;
    res_t r;
    res_t want;
    if (!rst_n) begin
      frame_results_due.delete();
      size_limit = MAX_PAYLOAD_RST;
      parse_ph   = PH_FIRST;
      hdr_left   = 4'd0;
      len_acc    = 64'd0;
      key_word   = 32'd0;
      body_left  = 32'd0;
      key_idx    = 2'd0;
      frm_fin    = 1'b0;
      frm_op     = 4'd0;
      frm_masked = 1'b0;
    end else begin
      // result word leaving the block
      if (out_valid && !out_stall) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual kind %0d byte %0h",
                   $time, out_kind, out_payload_byte);
          fault_count++;
        end else begin
          want = frame_results_due.pop_front();
          compare_field("kind", want.kind, out_kind);
          compare_field("fin", want.fin, out_fin);
          compare_field("opcode", want.opcode, out_opcode);
          compare_field("masked", want.masked, out_masked);
          compare_field("payload_length", want.payload_length, out_payload_length);
          compare_field("payload_byte", want.payload_byte, out_payload_byte);
          compare_field("last", want.last, out_last);
          compare_field("error_code", want.error_code, out_error_code);
        end
      end
      // stream byte entering the block
      if (in_valid && !in_stall) begin
        deframe_byte(in_data_byte, got, r);
        if (got) frame_results_due.push_back(r);
      end
      // register port
      if (psel && penable && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
        if (pwrite) size_limit = pwdata;
        else compare_field("prdata", size_limit, prdata);
      end
    end
    results_due = frame_results_due.size();
  end

endmodule

>>> tb/tb_websocket_frame_parser_top.sv
// tb_websocket_frame_parser_top: stimulus and verdict for the websocket frame parser
// drives frames, size limits and receiver stalls; wsfp_frame_checker does the checking
// depends on wsfp_pkg, websocket_frame_parser_top and wsfp_frame_checker

module tb_websocket_frame_parser_top;
  import wsfp_pkg::*;

  localparam int          HALF_PERIOD  = 4;
  localparam int          RESET_CYCLES = 6;
  localparam int          ITEM_TARGET  = 650;
  // rough byte count of the directed frames, the closing error and frame overruns
  localparam int          FIXED_ITEMS  = 96;
  localparam int          LIMIT_CYCLES = 300000;
  localparam int          SETTLE       = 4;
  localparam logic [6:0]  LEN_EXT64    = 7'd127;
  localparam int          NUM_LIMITS   = 8;

  typedef enum int {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_mode_t;
  typedef enum int {END_RESERVED, END_OVER_LIMIT, END_OVER_WIDTH} end_case_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic        out_masked;
  logic [31:0] out_payload_length;
  logic [7:0]  out_payload_byte;
  logic        out_last;
  logic        out_error_code;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fault_count;
  int          results_due;
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [31:0] cur_limit  = MAX_PAYLOAD_RST;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  logic [7:0]  stall_pat  = 8'h00;

  websocket_frame_parser_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_fin            (out_fin),
    .out_opcode         (out_opcode),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .out_error_code     (out_error_code),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  wsfp_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_fin            (out_fin),
    .out_opcode         (out_opcode),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_payload_byte   (out_payload_byte),
    .out_last           (out_last),
    .out_error_code     (out_error_code),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .fault_count        (fault_count),
    .results_due        (results_due)
  );

  // clock
  always #HALF_PERIOD clk = ~clk;

  // receiver stall, switching between patterns after runs of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 160);
      stall_pat  = 8'($urandom) & 8'hfe;
    end
    stall_left--;
    stall_pat = {stall_pat[6:0], stall_pat[7]};
    case (stall_mode)
      STALL_NONE:    out_stall <= 1'b0;
      STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PATTERN: out_stall <= stall_pat[0];
      default:       out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // run limit
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("** websocket_frame_parser_top: FAILED **");
    $finish;
  end

  // one stream word, sent in bursts with random gaps between them
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // hold the stream until every predicted result has left, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (results_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register access: setup phase then access phase
  task automatic reg_access(input logic wr, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_size_limit(input logic [31:0] v);
    reg_access(1'b1, v);
    reg_access(1'b0, 32'd0);
    cur_limit = v;
  endtask

  // header, optional mask key, optional body of random bytes
  task automatic send_frame(input logic [7:0] b0, input logic [63:0] len, input bit masked,
                            input len_enc_t enc, input bit with_body);
    int r;
    push_byte(b0);
    case (enc)
      ENC_SHORT: push_byte({masked, len[6:0]});
      ENC_EXT16: begin
        push_byte({masked, LEN_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) push_byte(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 0; i < MASK_BYTES; i++) push_byte(8'($urandom));
    if (with_body)
      for (int unsigned i = 0; i < len[31:0]; i++) begin
        r = $urandom_range(0, 9);
        push_byte((r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom));
      end
  endtask

  function automatic logic [7:0] random_first_byte();
    return {1'($urandom), 3'b000, 4'($urandom_range(0, 15))};
  endfunction

  // mostly short frames, some at the limit and around the 7-bit boundary
  function automatic int unsigned pick_len(input logic [31:0] lim);
    int unsigned cap;
    int unsigned r;
    cap = (lim < 32'd300) ? lim : 300;
    r = $urandom_range(0, 99);
    if (r < 5) return cap;
    if (r < 45) return $urandom_range(0, (cap < 6) ? cap : 6);
    if (r < 80) return $urandom_range(0, (cap < 30) ? cap : 30);
    if (r < 92) begin
      r = $urandom_range(120, 130);
      return (r < cap) ? r : cap;
    end
    return $urandom_range(0, cap);
  endfunction

  // shortest encoding most of the time, longer ones now and then
  function automatic len_enc_t pick_enc(input logic [63:0] len);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (len <= LEN7_MAX) return (r < 70) ? ENC_SHORT : (r < 85) ? ENC_EXT16 : ENC_EXT64;
    if (len <= 64'hffff) return (r < 80) ? ENC_EXT16 : ENC_EXT64;
    return ENC_EXT64;
  endfunction

  // stimulus
  initial begin
    logic [31:0] limits [NUM_LIMITS];
    int          phase_end;
    logic [31:0] budget;
    logic [63:0] len;
    logic [31:0] m;
    end_case_t   ending;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= 8'h00;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty frame, masked frame, 16-bit and 64-bit lengths
    send_frame(8'h81, 64'd0, 1'b0, ENC_SHORT, 1'b1);
    send_frame(8'h02, 64'd2, 1'b1, ENC_SHORT, 1'b1);
    send_frame(8'h8f, 64'd1, 1'b0, ENC_EXT16, 1'b1);
    send_frame(8'h00, 64'd1, 1'b0, ENC_EXT64, 1'b1);

    // random frames under a series of size limits, bodies kept within each phase's share
    limits = '{32'd0, 32'hffff_ffff, 32'd1, 32'd126, 32'($urandom_range(2, 400)),
               32'd125, 32'd3, 32'hffff_fffe};
    for (int p = 0; p < NUM_LIMITS; p++) begin
      drain_results();
      set_size_limit(limits[p]);
      phase_end = bytes_sent + (ITEM_TARGET - FIXED_ITEMS) / NUM_LIMITS;
      while (bytes_sent < phase_end) begin
        if ($urandom_range(0, 19) == 0) drain_results();
        budget = 32'(phase_end - bytes_sent);
        len = pick_len((cur_limit < budget) ? cur_limit : budget);
        send_frame(random_first_byte(), len, 1'($urandom), pick_enc(len), 1'b1);
      end
    end

    // one terminal error, then bytes the block must ignore
    drain_results();
    ending = end_case_t'($urandom_range(0, 2));
    case (ending)
      END_RESERVED:
        push_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom_range(0, 15))});
      END_OVER_LIMIT: begin
        m = $urandom_range(0, 200);
        set_size_limit(m);
        len = {32'd0, m} + 64'd1;
        send_frame(random_first_byte(), len, 1'($urandom), pick_enc(len), 1'b0);
      end
      default: begin
        set_size_limit(32'hffff_ffff);
        len = {32'($urandom_range(1, 32'hffff_ffff)), 32'($urandom)};
        send_frame(random_first_byte(), len, 1'($urandom), ENC_EXT64, 1'b0);
      end
    endcase
    for (int i = 0; i < 24; i++) push_byte(8'($urandom));

    drain_results();
    repeat (12) @(posedge clk);
    if (fault_count == 0 && results_due == 0)
      $display("** websocket_frame_parser_top: PASSED **");
    else
      $display("** websocket_frame_parser_top: FAILED **");
    $finish;
  end

endmodule
